// ===== design/uart_baud_divisor_macros.svh =====
// Assertion macros for the uart_baud_divisor block.
// Included by uart_baud_divisor.sv; no other dependencies.
`ifndef UART_BAUD_DIVISOR_MACROS_SVH
`define UART_BAUD_DIVISOR_MACROS_SVH

// Concurrent check sampled on the rising clock, disabled during reset.
`define UBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check on the block's own i_clk and i_rst_n.
`define UBD_CHECK(lbl, prop, msg) \
    `UBD_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== design/ubd_pkg.sv =====
// Package for the uart_baud_divisor block: types and constants.
// No dependencies.
package ubd_pkg;

    localparam int NUM_W  = 37;   // clock_hz * 25
    localparam int DEN_W  = 34;   // (2 or 4) * baud
    localparam int Q_W    = 37;   // quotient div100
    localparam int X_W    = 19;   // div100 below the overflow bound
    localparam int MANT_W = 13;

    // div100 at or above this bound always gives a word over 16 bits
    localparam logic [Q_W-1:0] DIV100_LIMIT = Q_W'(409600);
    // reciprocal of 100 scaled by 2^24 (rounded down), and of 100 scaled by 2^12
    localparam logic [17:0] RECIP_100_24 = 18'd167772;
    localparam logic [5:0]  RECIP_100_12 = 6'd41;
    localparam logic [15:0] WORD_MAX     = 16'hFFFF;

    // Data carried from cell to cell in the divider chain
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [Q_W-1:0]   quo;
        logic [DEN_W-1:0] den;
        logic             over8;
        logic             zero;
    } t_cell_data;

endpackage

// ===== design/ubd_if.sv =====
// Valid/ready channel interfaces for the uart_baud_divisor block.
// No dependencies.
interface ubd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] clock_hz;
    logic [31:0] baud;
    logic        oversample_by_eight;
    modport source (output valid, clock_hz, baud, oversample_by_eight, input ready);
    modport sink   (input valid, clock_hz, baud, oversample_by_eight, output ready);
endinterface

interface ubd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] divisor_word;
    logic        range_error;
    modport source (output valid, divisor_word, range_error, input ready);
    modport sink   (input valid, divisor_word, range_error, output ready);
endinterface

// ===== design/ubd_cell.sv =====
// One restoring-division cell: produces one quotient bit per item.
// Depends on ubd_pkg.
module ubd_cell
    import ubd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_cell_data i_data,
    output logic       o_valid,
    output t_cell_data o_data
);
    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic [DEN_W:0] shifted;
    logic           ge;

    // shift in next dividend bit, subtract divisor if it fits
    always_comb begin
        shifted = {i_data.rem, i_data.num[NUM_W-1]};
        ge      = (shifted >= {1'b0, i_data.den});
        n_data  = i_data;
        n_data.num = {i_data.num[NUM_W-2:0], 1'b0};
        n_data.quo = {i_data.quo[Q_W-2:0], ge};
        if (ge) begin
            n_data.rem = DEN_W'(shifted - {1'b0, i_data.den});
        end else begin
            n_data.rem = shifted[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== design/ubd_post.sv =====
// Splits div100 into mantissa and rounded fraction, forms the word.
// Two registered stages. Depends on ubd_pkg.
module ubd_post
    import ubd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [Q_W-1:0]   i_quo,
    input  logic             i_over8,
    input  logic             i_zero,
    output logic             o_valid,
    output logic [15:0]      o_word,
    output logic             o_error
);
    logic              r_valid1, r_valid2;
    logic [MANT_W-1:0] r_mant;
    logic [X_W-1:0]    r_x;
    logic              r_over8, r_err1;
    logic [15:0]       r_word;
    logic              r_err2;

    logic [X_W+17:0]   prod;
    logic [X_W-1:0]    rem_full;
    logic [MANT_W-1:0] mant;
    logic [6:0]        rem;
    logic [10:0]       scaled;
    logic [16:0]       fprod;
    logic [4:0]        frac;
    logic [16:0]       word;

    // stage 1: mantissa estimate by reciprocal multiply, at most one low
    assign prod = {18'd0, i_quo[X_W-1:0]} * {{X_W{1'b0}}, RECIP_100_24};

    // stage 2: correct estimate, round fraction, assemble word
    always_comb begin
        rem_full = r_x - X_W'({r_mant, 6'd0} + {r_mant, 5'd0} + {r_mant, 2'd0});
        mant     = r_mant;
        if (rem_full >= X_W'(100)) begin
            mant     = r_mant + 1'b1;
            rem_full = rem_full - X_W'(100);
        end
        rem    = rem_full[6:0];
        scaled = r_over8 ? ({1'b0, rem, 3'd0} + 11'd50) : ({rem, 4'd0} + 11'd50);
        fprod  = {6'd0, scaled} * {11'd0, RECIP_100_12};
        frac   = fprod[16:12];
        // 8x mode: a rounding carry skips bit 3 and lands in the mantissa
        word   = {mant, 4'd0} + (r_over8 ? {12'd0, frac[3], 1'b0, frac[2:0]}
                                         : {12'd0, frac});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant  <= prod[X_W+17:24];
            r_x     <= i_quo[X_W-1:0];
            r_over8 <= i_over8;
            r_err1  <= i_zero || (i_quo >= DIV100_LIMIT);
            r_err2  <= r_err1 || word[16];
            r_word  <= (r_err1 || word[16]) ? WORD_MAX : word[15:0];
        end
    end

    assign o_valid = r_valid2;
    assign o_word  = r_word;
    assign o_error = r_err2;
endmodule

// ===== design/uart_baud_divisor.sv =====
// Top level of the UART baud register word calculator.
// Depends on ubd_pkg, ubd_if, ubd_cell, ubd_post and the macros header.
//
// Usage: items enter on i_item (clock_hz, baud, oversample_by_eight) and one
// result per item leaves on o_item (divisor_word, range_error), valid/ready.
// The divisor clock_hz*25 / ((2 or 4)*baud) is found by a row of 37
// restoring-division cells, one quotient bit per cell, then two stages
// split it into mantissa and rounded fraction.
// From acceptance an item passes 37 cell registers, then two ubd_post ones.
// Throughput: one item per cycle unless stalled; all cells advance together.
// A zero baud or a word above 16 bits gives 0xFFFF with range_error set.
// Reset clears all valid flags; no item is in flight afterwards.
// When the receiver stalls, the whole row holds and i_item.ready drops only
// while the output register is full and not taken; bubbles hold in place.
`include "uart_baud_divisor_macros.svh"
module uart_baud_divisor
    import ubd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ubd_in_if.sink    i_item,
    ubd_out_if.source o_item
);
    logic       en;
    logic       err_out;
    logic       v   [0:Q_W];
    t_cell_data d   [0:Q_W];

    // whole pipeline advances when the output slot is free or taken
    assign en           = !o_item.valid || o_item.ready;
    assign i_item.ready = en;

    // load the chain
    always_comb begin
        v[0]       = i_item.valid;
        d[0].rem   = '0;
        d[0].num   = {5'd0, i_item.clock_hz} * NUM_W'(25);
        d[0].quo   = '0;
        d[0].den   = i_item.oversample_by_eight ? {1'b0, i_item.baud, 1'b0}
                                                : {i_item.baud, 2'b00};
        d[0].over8 = i_item.oversample_by_eight;
        d[0].zero  = (i_item.baud == 32'd0);
    end

    // row of division cells
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        ubd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_data  (d[g]),
            .o_valid (v[g+1]),
            .o_data  (d[g+1])
        );
    end

    ubd_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[Q_W]),
        .i_quo   (d[Q_W].quo),
        .i_over8 (d[Q_W].over8),
        .i_zero  (d[Q_W].zero),
        .o_valid (o_item.valid),
        .o_word  (o_item.divisor_word),
        .o_error (o_item.range_error)
    );

    // error flag on a valid result
    assign err_out = o_item.valid && o_item.range_error;

    `UBD_CHECK(a_err_sat, err_out |-> (o_item.divisor_word == WORD_MAX), "word not saturated")
    `UBD_CHECK(a_empty_ready, !o_item.valid |-> i_item.ready, "idle output but input stalled")
    `UBD_CHECK(a_rise_moved, $rose(o_item.valid) |-> $past(en), "result rose while held")
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for uart_baud_divisor: directed and random items, predicted word check.
// Depends on ubd_pkg, ubd_if and the uart_baud_divisor RTL.
module tb;
    import ubd_pkg::*;

    typedef struct packed {
        logic [31:0] clock_hz;
        logic [31:0] baud;
        logic        over8;
    } t_req;

    typedef struct packed {
        logic [15:0] word;
        logic        err;
    } t_brr;

    logic i_clk;
    logic i_rst_n;

    ubd_in_if  in_ch();
    ubd_out_if out_ch();

    uart_baud_divisor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch),
        .o_item  (out_ch)
    );

    t_req  pending_reqs[$];
    t_brr  expected_words[$];
    int    fail_count = 0;
    bit    stim_done = 0;
    bit    hold_sender = 0;
    bit    drain_wait = 0;

    // Baud register word for one request
    function automatic t_brr calc_brr(t_req r);
        t_brr        res;
        logic [63:0] div100, mant, remd, frac, w;
        if (r.baud == 0) begin
            res.word = WORD_MAX;
            res.err  = 1'b1;
            return res;
        end
        div100 = (64'(r.clock_hz) * 25) / ((r.over8 ? 64'd2 : 64'd4) * 64'(r.baud));
        mant   = div100 / 100;
        remd   = div100 - mant * 100;
        frac   = (remd * (r.over8 ? 64'd8 : 64'd16) + 50) / 100;
        // 8x mode: rounding carry moves up past bit 3
        if (r.over8)
            w = mant * 16 + ((frac & 64'hF8) << 1) + (frac & 64'h07);
        else
            w = mant * 16 + frac;
        res.err  = (w > 64'hFFFF);
        res.word = res.err ? WORD_MAX : w[15:0];
        return res;
    endfunction

    function automatic t_req mk_req(logic [31:0] c, logic [31:0] b, logic o);
        t_req r;
        r.clock_hz = c;
        r.baud     = b;
        r.over8    = o;
        return r;
    endfunction

    // Clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Driver: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid)
                expected_words.push_back(calc_brr(mk_req(in_ch.clock_hz, in_ch.baud,
                                                          in_ch.oversample_by_eight)));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                t_req r;
                r = pending_reqs.pop_front();
                in_ch.valid               <= 1'b1;
                in_ch.clock_hz            <= r.clock_hz;
                in_ch.baud                <= r.baud;
                in_ch.oversample_by_eight <= r.over8;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off
    int stall_mode = 0;
    int long_hold = 0;
    bit long_done = 0;
    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            out_ch.ready <= 1'b0;
        end else if (!long_done && cyc > 400) begin
            long_done <= 1'b1;
            long_hold <= 200;
            out_ch.ready <= 1'b0;
        end else begin
            if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 1) != 0);
                default: out_ch.ready <= ((cyc % 5) != 0);
            endcase
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word=%h err=%b",
                       out_ch.divisor_word, out_ch.range_error);
                fail_count++;
            end else begin
                t_brr e;
                e = expected_words.pop_front();
                if (out_ch.divisor_word !== e.word) begin
                    $error("divisor_word expected %h actual %h", e.word,
                           out_ch.divisor_word);
                    fail_count++;
                end
                if (out_ch.range_error !== e.err) begin
                    $error("range_error expected %b actual %b", e.err,
                           out_ch.range_error);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            3: return 32'(1) << $urandom_range(0, 31);
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    // Stimulus
    initial begin
        logic [31:0] c, b;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.clock_hz = 0;
        in_ch.baud = 0;
        in_ch.oversample_by_eight = 0;
        out_ch.ready = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, zero baud, zero clock, overflow, rounding carry
        for (int o = 0; o < 2; o++) begin
            pending_reqs.push_back(mk_req(32'd0, 32'd0, 1'(o)));
            pending_reqs.push_back(mk_req(32'hFFFF_FFFF, 32'd0, 1'(o)));
            pending_reqs.push_back(mk_req(32'd0, 32'd9600, 1'(o)));
            pending_reqs.push_back(mk_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'(o)));
            pending_reqs.push_back(mk_req(32'hFFFF_FFFF, 32'd1, 1'(o)));
            pending_reqs.push_back(mk_req(32'd1, 32'hFFFF_FFFF, 1'(o)));
            pending_reqs.push_back(mk_req(32'd84_000_000, 32'd115200, 1'(o)));
            pending_reqs.push_back(mk_req(32'd16_000_000, 32'd9600, 1'(o)));
            pending_reqs.push_back(mk_req(32'd16_000_000, 32'd15, 1'(o)));
            pending_reqs.push_back(mk_req(32'd16_000_000, 32'd16, 1'(o)));
            pending_reqs.push_back(mk_req(32'd1599, 32'd100, 1'(o)));
            pending_reqs.push_back(mk_req(32'd42_000_000, 32'd921600, 1'(o)));
        end

        // Random, then a pause until drained, then more random
        for (int i = 0; i < 1200; i++) begin
            c = rand_field();
            b = rand_field();
            // keep many words in range: baud from clock/2^19 up to about clock/16
            if ($urandom_range(0, 1)) b = (c >> $urandom_range(4, 19)) + $urandom_range(0, 3);
            pending_reqs.push_back(mk_req(c, b, 1'($urandom_range(0, 1))));
            if (i == 600) begin
                wait (pending_reqs.size() == 0);
                hold_sender = 1;
                wait (expected_words.size() == 0 && !in_ch.valid);
                hold_sender = 0;
            end
        end
        wait (pending_reqs.size() == 0 && !in_ch.valid);
        wait (expected_words.size() == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("uart_baud_divisor: match");
        else
            $display("uart_baud_divisor: mismatch");
        $finish;
    end

    // Timeout
    initial begin
        #2_000_000;
        $display("uart_baud_divisor: mismatch");
        $finish;
    end
endmodule
